// File: hdl/exg_pkg.sv
// ----------------------------------------------------------------------------
// exg_pkg
// Shared types and codes for the Exp-Golomb bit writer: input and result
// words, item kinds, status codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package exg_pkg;

  // Number of low value bits that are coded.
  localparam int VALUE_WIDTH = 32;

  localparam int KIND_W   = 3;
  localparam int WIDTH_W  = 6;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 25;
  localparam int STATUS_W = 2;
  localparam int BYTE_W   = 8;

  // Reset value of the byte limit register.
  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(16777216);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_RAW     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_UE      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SE      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_LIMIT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ENC = 2'd2;

  // One input word.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [WIDTH_W-1:0] width;
    logic [DATA_W-1:0]  value;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic                last;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  bytes_written;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the input word
    logic prep;   // set up the bit field for the item
    logic len;    // size the Exp-Golomb code word
    logic run;    // pack bits, at most one byte per cycle
  } exg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_len;   // item needs the code length step
    logic item_done;  // last packing step of the item fired
  } exg_sts_t;

endpackage

// File: hdl/exp_golomb_bit_writer.sv
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer
// MSB-first bit packer with raw, unsigned and signed Exp-Golomb writes,
// flush and restart, and a configurable output byte limit.
//
//   Channel  Direction  Handshake             Word
//   in       input      in_valid / in_stall   in_word_t (kind, width, value)
//   out      output     out_valid / out_stall out_word_t (byte and status)
//   cfg      input      cfg_wr_en             byte_limit, 25 bits
//
// A word is captured, then set up, then for encodable Exp-Golomb kinds the
// code is sized; the byte packer then gives the result words, and trailing
// bits go into the partial byte. The next word waits until this one is done.
// The packer moves at most one byte a cycle; a stalled result register
// holds it back. Reset clears the partial byte and the count and sets the
// byte limit to 16777216.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  exg_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output exg_pkg::out_word_t          out_word,
  input  logic                        cfg_wr_en,
  input  logic [exg_pkg::COUNT_W-1:0] cfg_wr_data
);
  import exg_pkg::*;

  exg_cmd_t cmd;
  exg_sts_t sts;

  // Sequencer.
  exg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Coder and byte packer.
  exg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (in_word),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

// File: hdl/exg_ctrl.sv
// ----------------------------------------------------------------------------
// exg_ctrl
// Sequencer for the Exp-Golomb bit writer: takes one word at a time and
// walks it through the prepare, length and packing steps of the datapath.
// ----------------------------------------------------------------------------
module exg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output exg_pkg::exg_cmd_t cmd,
  input  exg_pkg::exg_sts_t sts
);
  import exg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_LEN  = 4'b0100,
    ST_RUN  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = sts.need_len ? ST_LEN : ST_RUN;
      end
      ST_LEN: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (sts.item_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Handshake and datapath commands.
  assign in_stall = (state != ST_IDLE);
  assign cmd.load = (state == ST_IDLE) && in_valid;
  assign cmd.prep = (state == ST_PREP);
  assign cmd.len  = (state == ST_LEN);
  assign cmd.run  = (state == ST_RUN);

endmodule

// File: hdl/exg_datapath.sv
// ----------------------------------------------------------------------------
// exg_datapath
// Datapath of the Exp-Golomb bit writer: item register, code word builder,
// code length finder, byte packer with limit check, and the result register.
// ----------------------------------------------------------------------------
module exg_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [exg_pkg::COUNT_W-1:0]      cfg_wr_data,
  input  exg_pkg::in_word_t                in_word,
  input  exg_pkg::exg_cmd_t                cmd,
  output exg_pkg::exg_sts_t                sts,
  output logic                             out_valid,
  input  logic                             out_stall,
  output exg_pkg::out_word_t               out_word
);
  import exg_pkg::*;

  localparam logic [DATA_W-1:0]  VMASK = DATA_W'((64'd1 << VALUE_WIDTH) - 64'd1);
  localparam logic [DATA_W-1:0]  VSIGN = DATA_W'(64'd1 << (VALUE_WIDTH - 1));
  localparam logic [WIDTH_W-1:0] VW    = WIDTH_W'(VALUE_WIDTH);

  // Index of the highest set bit of a 4-bit group.
  function automatic logic [1:0] msb4(input logic [3:0] x);
    logic [1:0] idx;
    idx = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (x[i]) begin
        idx = 2'(i);
      end
    end
    return idx;
  endfunction

  // Index of the highest set bit of a byte.
  function automatic logic [2:0] msb8(input logic [7:0] x);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) begin
        idx = 3'(i);
      end
    end
    return idx;
  endfunction

  // Configuration and writer state.
  logic [COUNT_W-1:0]  byte_limit;
  logic [6:0]          partial;
  logic [2:0]          pcount;
  logic [COUNT_W-1:0]  emitted;

  // Item registers.
  logic [KIND_W-1:0]   kind;
  logic [WIDTH_W-1:0]  width;
  logic [DATA_W-1:0]   value;

  // Bit field being packed: the low rem bits of code, zeros above bit 31.
  logic [DATA_W-1:0]   code;
  logic [3:0]          nz;
  logic [WIDTH_W-1:0]  rem;
  logic [STATUS_W-1:0] st;
  logic                sent;

  // Code word setup.
  logic [DATA_W-1:0]   vin;
  logic [DATA_W-1:0]   mag;
  logic [DATA_W-1:0]   code_c;
  logic                not_enc;

  always_comb begin
    vin     = value & VMASK;
    mag     = ((VMASK ^ vin) + DATA_W'(1)) & VMASK;
    not_enc = 1'b0;
    code_c  = vin + DATA_W'(1);
    if (kind == KIND_UE) begin
      not_enc = (vin == VMASK);
    end else if (kind == KIND_SE) begin
      not_enc = (vin == VSIGN);
      if (vin == '0) begin
        code_c = DATA_W'(1);
      end else if ((vin & VSIGN) != '0) begin
        code_c = {mag[DATA_W-2:0], 1'b1};
      end else begin
        code_c = {vin[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Code length: 2*nbits - 1 where nbits is the length of the code word.
  logic [1:0]         top_grp;
  logic [7:0]         top_byte;
  logic [2:0]         top_pos;
  logic [WIDTH_W-1:0] len_c;

  always_comb begin
    top_grp  = msb4(nz);
    top_byte = code[{top_grp, 3'b000} +: 8];
    top_pos  = msb8(top_byte);
    len_c    = {top_grp, top_pos, 1'b1};
  end

  // Packing step: take up to one byte's worth of bits.
  logic [3:0]         room;
  logic [3:0]         k;
  logic               fill;
  logic [71:0]        wide;
  logic [7:0]         newbits;
  logic [7:0]         acc;
  logic [COUNT_W-1:0] emitted_inc;
  logic [WIDTH_W-1:0] rem_after;
  logic               refused;
  logic               refuse_next;
  logic               final_word;
  logic               ends;
  logic               needs_out;
  logic               out_free;
  logic               step_go;
  logic [COUNT_W-1:0] bw_now;
  out_word_t          res;

  always_comb begin
    room        = 4'd8 - {1'b0, pcount};
    k           = (rem < {2'b00, room}) ? rem[3:0] : room;
    fill        = (({1'b0, pcount} + k) == 4'd8);
    wide        = {32'd0, code, 8'h00} >> rem;
    newbits     = wide[7:0] >> (4'd8 - k);
    acc         = ({1'b0, partial} << k) | newbits;
    emitted_inc = emitted + COUNT_W'(1);
    rem_after   = rem - {2'b00, k};
    refused     = (emitted >= byte_limit);
    refuse_next = (rem_after != '0) && (emitted_inc >= byte_limit);
    final_word  = refuse_next || (rem_after < WIDTH_W'(8));
    bw_now      = emitted + COUNT_W'(pcount != 3'd0);

    res            = '0;
    res.last       = 1'b1;
    ends           = 1'b1;
    needs_out      = !sent;
    priority if (rem == '0) begin
      res.status        = st;
      res.bytes_written = bw_now;
    end else if (refused) begin
      res.status        = STATUS_LIMIT;
      res.bytes_written = bw_now;
    end else if (fill) begin
      needs_out         = 1'b1;
      ends              = refuse_next || (rem_after == '0);
      res.out_byte      = acc;
      res.byte_valid    = 1'b1;
      res.last          = final_word;
      res.status        = refuse_next ? STATUS_LIMIT : STATUS_OK;
      res.bytes_written = emitted_inc +
                          COUNT_W'(final_word && !refuse_next && (rem_after != '0));
    end else begin
      // The rest of the field fits in the partial byte.
      res.status        = STATUS_OK;
      res.bytes_written = emitted + COUNT_W'(1);
    end

    out_free      = !out_valid || !out_stall;
    step_go       = cmd.run && (!needs_out || out_free);
    sts.item_done = step_go && ends;
    sts.need_len  = ((kind == KIND_UE) || (kind == KIND_SE)) && !not_enc;
  end

  // Byte limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      byte_limit <= cfg_wr_data;
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind  <= in_word.kind;
      width <= in_word.width;
      value <= in_word.value;
    end
  end

  // Bit field setup, length step and packing progress.
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      st   <= not_enc ? STATUS_NOT_ENC : STATUS_OK;
      sent <= 1'b0;
      unique case (kind)
        KIND_RAW: begin
          code <= vin;
          nz   <= '0;
          rem  <= (width > VW) ? VW : width;
        end
        KIND_UE, KIND_SE: begin
          code <= code_c;
          nz   <= {|code_c[31:24], |code_c[23:16], |code_c[15:8], |code_c[7:0]};
          rem  <= '0;
        end
        KIND_FLUSH: begin
          code <= '0;
          nz   <= '0;
          rem  <= (pcount == 3'd0) ? WIDTH_W'(0) : WIDTH_W'(4'd8 - {1'b0, pcount});
        end
        default: begin
          code <= '0;
          nz   <= '0;
          rem  <= '0;
        end
      endcase
    end else if (cmd.len) begin
      rem <= len_c;
    end else if (step_go && (rem != '0) && !refused) begin
      rem <= rem_after;
      if (fill) begin
        sent <= final_word;
      end
    end
  end

  // Partial byte and emitted count.
  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      pcount  <= '0;
      emitted <= '0;
    end else if (cmd.prep && (kind == KIND_RESTART)) begin
      partial <= '0;
      pcount  <= '0;
      emitted <= '0;
    end else if (step_go && (rem != '0) && !refused) begin
      if (fill) begin
        partial <= '0;
        pcount  <= '0;
        emitted <= emitted_inc;
      end else begin
        partial <= acc[6:0];
        pcount  <= 3'(({1'b0, pcount} + k));
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step_go && needs_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && needs_out) begin
      out_word <= res;
    end
  end

endmodule
